[rtl/soc_pkg.sv]
// ----------------------------------------------------------------------------
// soc_pkg
// Shared widths, constants and pipeline control type of the sine oscillator.
// ----------------------------------------------------------------------------
package soc_pkg;

    localparam int INC_W = 32;
    localparam int AMP_W = 16;
    localparam int OUT_W = 16;

    // pi/2 in Q30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // per-stage control: upstream holds a beat, this stage may load
    typedef struct packed {
        logic vld;
        logic adv;
    } t_stage;

endpackage

[rtl/sine_oscillator_with_sync.sv]
// ----------------------------------------------------------------------------
// sine_oscillator_with_sync
// Sine oscillator with hard sync: phase accumulator, quarter-wave table,
// amplitude scaling with rounding and saturation.
//
//   channel  dir  handshake           fields
//   in       in   i_valid / o_stall   i_phase_increment, i_amplitude,
//                                     i_sync_level
//   out      out  o_valid / i_stall   o_sample
//
// One beat per clock unless the output stalls, set by the phase adder loop.
// Four stages (phase, table read, multiply, round/saturate). A stage loads when
// empty or when the next one loads, so bubbles close up; a stalled output stops
// input once all four stages are full. Synchronous active-low reset clears the
// phase, the sync history and all valids; the table is constant and needs no
// fill.
// ----------------------------------------------------------------------------
module sine_oscillator_with_sync
    import soc_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [INC_W-1:0]    i_phase_increment,
    input  logic [AMP_W-1:0]    i_amplitude,
    input  logic                i_sync_level,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [OUT_W-1:0]    o_sample
);

    logic                   w_v1, w_v2, w_v3, w_v4;
    logic                   w_adv1, w_adv2, w_adv3, w_adv4;
    t_stage                 w_ctl1, w_ctl2, w_ctl3, w_ctl4;
    logic [PHASE_BITS-1:0]  w_phase;
    logic [AMP_W-1:0]       w_amp1, w_amp2;
    logic [SAMPLE_BITS-2:0] w_mag;
    logic                   w_neg;

    assign w_adv4 = !w_v4 || !i_stall;
    assign w_adv3 = !w_v3 || w_adv4;
    assign w_adv2 = !w_v2 || w_adv3;
    assign w_adv1 = !w_v1 || w_adv2;

    assign w_ctl1 = '{vld: i_valid, adv: w_adv1};
    assign w_ctl2 = '{vld: w_v1,    adv: w_adv2};
    assign w_ctl3 = '{vld: w_v2,    adv: w_adv3};
    assign w_ctl4 = '{vld: w_v3,    adv: w_adv4};

    assign o_stall = !w_adv1;
    assign o_valid = w_v4;

    soc_phase #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (w_ctl1),
        .i_phase_increment (i_phase_increment),
        .i_amplitude       (i_amplitude),
        .i_sync_level      (i_sync_level),
        .o_vld             (w_v1),
        .o_phase           (w_phase),
        .o_amp             (w_amp1)
    );

    soc_rom #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_rom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl2),
        .i_phase (w_phase),
        .i_amp   (w_amp1),
        .o_vld   (w_v2),
        .o_mag   (w_mag),
        .o_neg   (w_neg),
        .o_amp   (w_amp2)
    );

    soc_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mul_ctl (w_ctl3),
        .i_out_ctl (w_ctl4),
        .i_mag     (w_mag),
        .i_neg     (w_neg),
        .i_amp     (w_amp2),
        .o_mul_vld (w_v3),
        .o_vld     (w_v4),
        .o_sample  (o_sample)
    );

`ifndef ASSERT_OFF
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (w_v1 && w_v2 && w_v3 && w_v4))
        else $error("input stalled with an empty stage");

    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_valid && !o_stall) |=> $stable(w_phase))
        else $error("phase moved without an accepted beat");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_v3))
        else $error("output beat without a product beat");
`endif

endmodule

[rtl/soc_phase.sv]
// ----------------------------------------------------------------------------
// soc_phase
// Phase accumulator with hard sync on a rising edge of the sync level.
// ----------------------------------------------------------------------------
module soc_phase
    import soc_pkg::*;
#(
    parameter int PHASE_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_stage                  i_ctl,
    input  logic [INC_W-1:0]        i_phase_increment,
    input  logic [AMP_W-1:0]        i_amplitude,
    input  logic                    i_sync_level,
    output logic                    o_vld,
    output logic [PHASE_BITS-1:0]   o_phase,
    output logic [AMP_W-1:0]        o_amp
);

    logic [PHASE_BITS-1:0] r_phase, n_phase;
    logic                  r_sync_prev;
    logic                  r_vld;
    logic [AMP_W-1:0]      r_amp;
    logic [PHASE_BITS-1:0] w_inc;
    logic                  w_take;

    generate
        if (PHASE_BITS > INC_W) begin : g_up
            assign w_inc = {i_phase_increment, {(PHASE_BITS-INC_W){1'b0}}};
        end else begin : g_dn
            // shift right, keep the high PHASE_BITS bits
            assign w_inc = i_phase_increment[INC_W-1 -: PHASE_BITS];
        end
    endgenerate

    assign w_take = i_ctl.vld && i_ctl.adv;

    always_comb begin
        if (i_sync_level && !r_sync_prev) begin
            n_phase = '0;
        end else begin
            n_phase = r_phase + w_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_sync_prev <= 1'b0;
            r_vld       <= 1'b0;
        end else begin
            if (i_ctl.adv) begin
                r_vld <= i_ctl.vld;
            end
            if (w_take) begin
                r_phase     <= n_phase;
                r_sync_prev <= i_sync_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_amp <= i_amplitude;
        end
    end

    assign o_vld   = r_vld;
    assign o_phase = r_phase;
    assign o_amp   = r_amp;

endmodule

[rtl/soc_rom.sv]
// ----------------------------------------------------------------------------
// soc_rom
// Quarter-wave sine lookup: quadrant fold and registered table read.
// ----------------------------------------------------------------------------
module soc_rom
    import soc_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_stage                  i_ctl,
    input  logic [PHASE_BITS-1:0]   i_phase,
    input  logic [AMP_W-1:0]        i_amp,
    output logic                    o_vld,
    output logic [SAMPLE_BITS-2:0]  o_mag,
    output logic                    o_neg,
    output logic [AMP_W-1:0]        o_amp
);

    localparam int N = 1 << SINE_TABLE_BITS;

    typedef logic [SAMPLE_BITS-2:0] t_rom [0:N];

    function automatic logic [SAMPLE_BITS-2:0] f_entry(input longint unsigned i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint          s;
        longint          v;
        longint          fs;
        fs = (longint'(1) << (SAMPLE_BITS-1)) - 1;
        x  = (HALF_PI_Q30 * i) >> SINE_TABLE_BITS;
        x2 = (x * x) >> 30;
        t  = x;
        s  = longint'(x);
        t = ((t * x2) >> 30) / 64'd6;   s = s - longint'(t);
        t = ((t * x2) >> 30) / 64'd20;  s = s + longint'(t);
        t = ((t * x2) >> 30) / 64'd42;  s = s - longint'(t);
        t = ((t * x2) >> 30) / 64'd72;  s = s + longint'(t);
        t = ((t * x2) >> 30) / 64'd110; s = s - longint'(t);
        t = ((t * x2) >> 30) / 64'd156; s = s + longint'(t);
        t = ((t * x2) >> 30) / 64'd210; s = s - longint'(t);
        t = ((t * x2) >> 30) / 64'd272; s = s + longint'(t);
        t = ((t * x2) >> 30) / 64'd342; s = s - longint'(t);
        t = ((t * x2) >> 30) / 64'd420; s = s + longint'(t);
        if (s < 0) begin
            s = 0;
        end
        v = (s * fs + (longint'(1) << 29)) >>> 30;
        if (v > fs) begin
            v = fs;
        end
        return v[SAMPLE_BITS-2:0];
    endfunction

    function automatic t_rom f_build();
        t_rom rom;
        for (int i = 0; i <= N; i++) begin
            rom[i] = f_entry(longint'(i));
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = f_build();

    logic [1:0]                 w_quad;
    logic [SINE_TABLE_BITS-1:0] w_k;
    logic [SINE_TABLE_BITS:0]   w_idx;
    logic [SAMPLE_BITS-2:0]     r_mag;
    logic                       r_neg;
    logic                       r_vld;
    logic [AMP_W-1:0]           r_amp;

    assign w_quad = i_phase[PHASE_BITS-1 -: 2];
    assign w_k    = i_phase[PHASE_BITS-3 -: SINE_TABLE_BITS];
    assign w_idx  = w_quad[0] ? ((SINE_TABLE_BITS+1)'(N) - {1'b0, w_k}) : {1'b0, w_k};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.adv) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_mag <= SINE_ROM[w_idx];
            r_neg <= w_quad[1];
            r_amp <= i_amp;
        end
    end

    assign o_vld = r_vld;
    assign o_mag = r_mag;
    assign o_neg = r_neg;
    assign o_amp = r_amp;

endmodule

[rtl/soc_scale.sv]
// ----------------------------------------------------------------------------
// soc_scale
// Amplitude multiply, then round half up and saturate to Q1.15.
// ----------------------------------------------------------------------------
module soc_scale
    import soc_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_stage                  i_mul_ctl,
    input  t_stage                  i_out_ctl,
    input  logic [SAMPLE_BITS-2:0]  i_mag,
    input  logic                    i_neg,
    input  logic [AMP_W-1:0]        i_amp,
    output logic                    o_mul_vld,
    output logic                    o_vld,
    output logic [OUT_W-1:0]        o_sample
);

    localparam int PW = AMP_W + SAMPLE_BITS;
    localparam int SW = PW + 1;
    localparam int RW = SW - (SAMPLE_BITS - 1);

    localparam logic signed [SW-1:0] HALF_RND = SW'(1) << (SAMPLE_BITS - 2);
    localparam logic signed [RW-1:0] SAT_HI   = {{(RW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [RW-1:0] SAT_LO   = {{(RW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] w_sine;
    logic signed [PW-1:0]          r_prod;
    logic                          r_mul_vld;
    logic signed [SW-1:0]          w_sum;
    logic signed [RW-1:0]          w_rnd;
    logic [OUT_W-1:0]              w_sat;
    logic [OUT_W-1:0]              r_sample;
    logic                          r_vld;

    assign w_sine = i_neg ? -$signed({1'b0, i_mag}) : $signed({1'b0, i_mag});

    assign w_sum = {r_prod[PW-1], r_prod} + HALF_RND;
    assign w_rnd = w_sum[SW-1 -: RW];

    always_comb begin
        if (w_rnd > SAT_HI) begin
            w_sat = SAT_HI[OUT_W-1:0];
        end else if (w_rnd < SAT_LO) begin
            w_sat = SAT_LO[OUT_W-1:0];
        end else begin
            w_sat = w_rnd[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_vld <= 1'b0;
            r_vld     <= 1'b0;
        end else begin
            if (i_mul_ctl.adv) begin
                r_mul_vld <= i_mul_ctl.vld;
            end
            if (i_out_ctl.adv) begin
                r_vld <= i_out_ctl.vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mul_ctl.adv) begin
            r_prod <= PW'($signed(i_amp)) * PW'(w_sine);
        end
        if (i_out_ctl.adv) begin
            r_sample <= w_sat;
        end
    end

    assign o_mul_vld = r_mul_vld;
    assign o_vld     = r_vld;
    assign o_sample  = r_sample;

endmodule

[verif/tb_sine_oscillator_with_sync.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sine_oscillator_with_sync
// Self-checking bench for the hard-synced sine oscillator. A bit-exact
// predictor (phase accumulator, quarter-wave table, rounded Q1.15 product)
// computes each sample when its beat is accepted. A monitor checks every
// output beat in order against those samples. Directed tests cover the
// amplitude extremes, phase wrap and the sync edge cases. A random stream
// then runs under three backpressure profiles.
// ----------------------------------------------------------------------------
module tb_sine_oscillator_with_sync;
    import soc_pkg::*;

    localparam int TBL_BITS    = 10;
    localparam int TBL_N       = 1 << TBL_BITS;
    localparam int CYCLE_LIMIT = 300000;
    localparam longint FULL_SCALE = (64'sd1 << (OUT_W - 1)) - 1;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [INC_W-1:0] i_phase_increment;
    logic [AMP_W-1:0] i_amplitude;
    logic             i_sync_level;
    logic             o_valid;
    logic             i_stall;
    logic [OUT_W-1:0] o_sample;

    sine_oscillator_with_sync dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_phase_increment (i_phase_increment),
        .i_amplitude       (i_amplitude),
        .i_sync_level      (i_sync_level),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_sample          (o_sample)
    );

    int               qsine [0:TBL_N];
    logic [INC_W-1:0] osc_phase;
    logic             last_sync;
    logic [OUT_W-1:0] expected_samples [$];
    int               error_count;
    int               cycle_count;
    int               send_idle_pct;
    int               recv_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic void build_quarter_sine();
        longint unsigned x, x2, term;
        longint          sum, v;
        for (int i = 0; i <= TBL_N; i++) begin
            x    = (HALF_PI_Q30 * longint'(i)) / TBL_N;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 10; k++) begin
                term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                if (k % 2) begin
                    sum -= longint'(term);
                end else begin
                    sum += longint'(term);
                end
            end
            if (sum < 0) sum = 0;
            v = (sum * FULL_SCALE + (64'sd1 << 29)) >>> 30;
            if (v > FULL_SCALE) v = FULL_SCALE;
            qsine[i] = int'(v);
        end
    endfunction

    // advances the oscillator by one beat and returns its sample
    function automatic logic [OUT_W-1:0] next_sample(logic [INC_W-1:0] inc,
                                                     logic [AMP_W-1:0] amp,
                                                     logic sync);
        logic [1:0]          quad;
        logic [TBL_BITS-1:0] k;
        int                  idx;
        longint              sine, prod, r;
        if (sync && !last_sync) begin
            osc_phase = '0;
        end else begin
            osc_phase = osc_phase + inc;
        end
        last_sync = sync;
        quad = osc_phase[INC_W-1 -: 2];
        k    = osc_phase[INC_W-3 -: TBL_BITS];
        idx  = quad[0] ? TBL_N - int'(k) : int'(k);
        sine = quad[1] ? -longint'(qsine[idx]) : longint'(qsine[idx]);
        prod = longint'(signed'(amp)) * sine;
        r    = (prod + (64'sd1 << (OUT_W - 2))) >>> (OUT_W - 1);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[OUT_W-1:0];
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_samples.size() == 0) begin
                report_mismatch($sformatf("unexpected sample %0d",
                                          $signed(o_sample)));
            end else begin
                logic [OUT_W-1:0] want;
                want = expected_samples.pop_front();
                if (o_sample !== want) begin
                    report_mismatch($sformatf("sample got %0d exp %0d",
                                              $signed(o_sample), $signed(want)));
                end
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_beat(logic [INC_W-1:0] inc, logic [AMP_W-1:0] amp,
                             logic sync);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_phase_increment <= inc;
        i_amplitude       <= amp;
        i_sync_level      <= sync;
        do @(posedge i_clk); while (o_stall);
        expected_samples.push_back(next_sample(inc, amp, sync));
        @(negedge i_clk);
    endtask

    task automatic test_amplitude_extremes();
        send_beat(32'h4000_0000, 16'h7FFF, 1'b0);
        send_beat(32'h0000_0000, 16'h8000, 1'b0);
        send_beat(32'h0000_0000, 16'h0000, 1'b0);
        send_beat(32'h4000_0000, 16'h8000, 1'b0);
        send_beat(32'h0000_0000, 16'h7FFF, 1'b0);
        send_beat(32'h0000_0001, 16'h0001, 1'b0);
        send_beat(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    endtask

    task automatic test_phase_wrap();
        send_beat(32'h7FFF_FFFF, 16'h7FFF, 1'b0);
        send_beat(32'h8000_0000, 16'h7FFF, 1'b0);
        send_beat(32'h8000_0000, 16'h8000, 1'b0);
        send_beat(32'hC000_0000, 16'h7FFF, 1'b0);
        send_beat(32'h0010_0000, 16'h5A5A, 1'b0);
        send_beat(32'hFFF0_0000, 16'hA5A5, 1'b0);
    endtask

    task automatic test_hard_sync();
        send_beat(32'h1234_5678, 16'h7FFF, 1'b1);
        send_beat(32'h1000_0000, 16'h7FFF, 1'b1);
        send_beat(32'h1000_0000, 16'h7FFF, 1'b1);
        send_beat(32'h2000_0000, 16'h8000, 1'b0);
        send_beat(32'h3000_0000, 16'h4000, 1'b1);
        send_beat(32'h3000_0000, 16'h4000, 1'b0);
        send_beat(32'h3000_0000, 16'h4000, 1'b1);
    endtask

    task automatic test_random_stream(int count, int send_pct, int recv_pct);
        logic [INC_W-1:0] inc;
        logic [AMP_W-1:0] amp;
        logic             sync;
        int               pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sync = 1'b0;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(9);
            if (pick < 4) begin
                inc = 32'($urandom_range(0, 1 << 24));
                if ($urandom_range(1)) inc = -inc;
            end else if (pick < 8) begin
                inc = $urandom;
            end else begin
                case ($urandom_range(4))
                    0: inc = 32'h7FFF_FFFF;
                    1: inc = 32'h8000_0000;
                    2: inc = 32'h4000_0000;
                    3: inc = 32'hFFFF_FFFF;
                    default: inc = 32'h0000_0000;
                endcase
            end
            if ($urandom_range(99) < 85) begin
                amp = 16'($urandom);
            end else begin
                case ($urandom_range(4))
                    0: amp = 16'h7FFF;
                    1: amp = 16'h8000;
                    2: amp = 16'h0001;
                    3: amp = 16'hFFFF;
                    default: amp = 16'h0000;
                endcase
            end
            if ($urandom_range(9) == 0) sync = ~sync;
            send_beat(inc, amp, sync);
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_phase_increment = '0;
        i_amplitude       = '0;
        i_sync_level      = 1'b0;
        osc_phase         = '0;
        last_sync         = 1'b0;
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        build_quarter_sine();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_amplitude_extremes();
        test_phase_wrap();
        test_hard_sync();
        test_random_stream(477, 30, 87);
        test_random_stream(477, 87, 30);
        test_random_stream(477, 0, 0);

        i_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
